[src/tsp_pkg.sv]
package tsp_pkg;

   // Width of an open or closed field: values never exceed 2147483647.
   localparam int unsigned FIELD_W = 31;
   localparam int unsigned TOTAL_W = 53;
   localparam int unsigned MS_W    = FIELD_W + 4;

   localparam logic [FIELD_W-1:0] FIELD_MAX = 31'h7FFF_FFFF;

   localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [9:0]  MS_PER_SECOND = 10'd1000;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [1:0] DIGITS_TWO = 2'd2;
   localparam logic [1:0] DIGITS_SAT = 2'd3;

   // One character of the timestamp string.
   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic       last;
   } req_type;

   // Parse result for one complete string.
   typedef struct packed {
      logic               ok;
      logic [TOTAL_W-1:0] total_ms;
   } rsp_type;

endpackage

[src/timestamp_text_parser.sv]
// Timestamp text parser.
// The req_ channel carries one character of an "h:m:s.ms" string per
// transaction; has_char = 0 marks a transaction without a character, and
// last = 1 closes the string. Each closing transaction produces exactly one
// rsp_ transaction with an ok flag and the total in milliseconds (zero when
// the string fails). Other transactions produce nothing.
// Throughput is one req_ transaction per cycle while req_stall is low. Digits
// are folded into the open field in the cycle of acceptance; the result then
// passes through a field snapshot stage, a constant-multiply stage and a
// summing stage. The closing transaction loads the snapshot, then the product
// stage and the result register, from which the response is valid.
// Synchronous reset clears the parser state and empties the pipeline.
// When the receiver holds rsp_stall, the result register keeps its value and
// the stages behind it fill; once the snapshot stage is full and cannot move
// on, req_stall rises and every req_ transaction waits until it drains.
module timestamp_text_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsp_pkg::rsp_type rsp_data
);

   localparam int unsigned FW = tsp_pkg::FIELD_W;
   localparam int unsigned TW = tsp_pkg::TOTAL_W;
   localparam int unsigned MW = tsp_pkg::MS_W;

   // Parser state.
   logic [FW-1:0] field_ff, field_in;
   logic          overflow_ff, overflow_in;
   logic [1:0]    digits_ff, digits_in;
   logic [FW-1:0] secs_ff, secs_in;
   logic [FW-1:0] mins_ff, mins_in;
   logic [FW-1:0] hours_ff, hours_in;
   logic          sep_seen_ff, sep_seen_in;
   logic          seen_ff, seen_in;
   logic          bad_ff, bad_in;

   // Snapshot stage.
   logic          a_valid_ff;
   logic          a_ok_ff;
   logic [FW-1:0] a_hours_ff, a_mins_ff, a_secs_ff, a_ms_ff;
   logic          a_two_ff;

   // Product stage.
   logic          b_valid_ff;
   logic          b_ok_ff;
   logic [TW-1:0] b_hours_ff, b_mins_ff, b_secs_ff;
   logic [MW-1:0] b_ms_ff;

   // Result register.
   logic             rsp_valid_ff;
   tsp_pkg::rsp_type rsp_data_ff;

   logic c_ready, b_ready, a_ready, accept, close_str;
   logic is_digit, is_sep;
   logic [3:0]    digit_val;
   logic [FW+3:0] acc;
   logic [FW-1:0] closed_val;
   logic [FW-1:0] fin_ms;
   logic          fin_ok;
   logic [MW-1:0] ms_scaled;

   // Pipeline flow control.
   assign c_ready   = !rsp_valid_ff || !rsp_stall;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;
   assign close_str = accept && req_data.last;

   // Character classification and the decimal accumulate.
   assign is_digit  = (req_data.char_code >= tsp_pkg::CHAR_ZERO)
                   && (req_data.char_code <= tsp_pkg::CHAR_NINE);
   assign is_sep    = (req_data.char_code == tsp_pkg::CHAR_DOT)
                   || (req_data.char_code == tsp_pkg::CHAR_COLON);
   assign digit_val = req_data.char_code[3:0];
   assign acc       = {1'b0, field_ff, 3'b000} + {3'b000, field_ff, 1'b0}
                   + {(FW)'(0), digit_val};
   assign closed_val = overflow_ff ? '0 : field_ff;

   // Next parser state after the current character, before any clearing.
   always_comb begin
      field_in    = field_ff;
      overflow_in = overflow_ff;
      digits_in   = digits_ff;
      secs_in     = secs_ff;
      mins_in     = mins_ff;
      hours_in    = hours_ff;
      sep_seen_in = sep_seen_ff;
      seen_in     = seen_ff;
      bad_in      = bad_ff;
      if (req_data.has_char) begin
         seen_in = 1'b1;
         if (is_digit) begin
            if (overflow_ff || (acc > {4'b0000, tsp_pkg::FIELD_MAX})) begin
               overflow_in = 1'b1;
               field_in    = '0;
            end else begin
               field_in = acc[FW-1:0];
            end
            if (digits_ff != tsp_pkg::DIGITS_SAT) begin
               digits_in = digits_ff + 2'd1;
            end
         end else if (is_sep) begin
            hours_in    = mins_ff;
            mins_in     = secs_ff;
            secs_in     = closed_val;
            field_in    = '0;
            overflow_in = 1'b0;
            digits_in   = '0;
            sep_seen_in = 1'b1;
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   assign fin_ok = seen_in && !bad_in && sep_seen_in;
   assign fin_ms = overflow_in ? '0 : field_in;

   // State update; a closing transaction clears everything for the next string.
   always_ff @(posedge clock) begin
      if (reset || close_str) begin
         field_ff    <= '0;
         overflow_ff <= 1'b0;
         digits_ff   <= '0;
         secs_ff     <= '0;
         mins_ff     <= '0;
         hours_ff    <= '0;
         sep_seen_ff <= 1'b0;
         seen_ff     <= 1'b0;
         bad_ff      <= 1'b0;
      end else if (accept) begin
         field_ff    <= field_in;
         overflow_ff <= overflow_in;
         digits_ff   <= digits_in;
         secs_ff     <= secs_in;
         mins_ff     <= mins_in;
         hours_ff    <= hours_in;
         sep_seen_ff <= sep_seen_in;
         seen_ff     <= seen_in;
         bad_ff      <= bad_in;
      end
   end

   // Snapshot stage: the final fields, zeroed when the string failed.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= close_str;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && close_str) begin
         a_ok_ff    <= fin_ok;
         a_hours_ff <= fin_ok ? hours_in : '0;
         a_mins_ff  <= fin_ok ? mins_in : '0;
         a_secs_ff  <= fin_ok ? secs_in : '0;
         a_ms_ff    <= fin_ok ? fin_ms : '0;
         a_two_ff   <= (digits_in == tsp_pkg::DIGITS_TWO);
      end
   end

   // Product stage: constant multiplies, and the two-digit fraction scaled by ten.
   assign ms_scaled = a_two_ff ? ({1'b0, a_ms_ff, 3'b000} + {3'b000, a_ms_ff, 1'b0})
                               : {4'b0000, a_ms_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_ok_ff    <= a_ok_ff;
         b_hours_ff <= TW'(a_hours_ff) * TW'(tsp_pkg::MS_PER_HOUR);
         b_mins_ff  <= TW'(a_mins_ff) * TW'(tsp_pkg::MS_PER_MINUTE);
         b_secs_ff  <= TW'(a_secs_ff) * TW'(tsp_pkg::MS_PER_SECOND);
         b_ms_ff    <= ms_scaled;
      end
   end

   // Result register: the millisecond sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_ready) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && b_valid_ff) begin
         rsp_data_ff.ok       <= b_ok_ff;
         rsp_data_ff.total_ms <= b_hours_ff + b_mins_ff + b_secs_ff + TW'(b_ms_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
